// File: design/scr_pkg.sv
// scr_pkg: shared types, constants and the cordic arctangent table
// for the splat circle/line rasterizer. no dependencies.
package scr_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] IMAGE_DIM_RESET = 10'd512;

  localparam logic [15:0] GRAY_LEVEL = 16'd50592;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [3:0] CORDIC_LAST = 4'd15;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CIRCLE = 2'd2,
    REQ_LINE   = 2'd3
  } req_type_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ACCESS, S_RESP, S_CINIT, S_CTEST, S_PT, S_NB, S_NBW, S_RET,
    S_SQX, S_SQY, S_CSTEP, S_LINIT, S_COR, S_CDONE, S_LNEXT, S_MX, S_MY
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ACCESS, OP_PUBLISH, OP_CIR_INIT, OP_PT_RESET, OP_PT_LOAD,
    OP_NB_READ, OP_NB_SKIP, OP_NB_WRITE, OP_PT_NEXT, OP_SQX, OP_SQY, OP_CIR_STEP,
    OP_COR_INIT, OP_COR_STEP, OP_COR_DONE, OP_LINE_NEXT, OP_MULX, OP_MULY
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic nb_inside;
    logic nb_last;
    logic pt_last;
    logic is_circle;
    logic circ_go;
    logic cor_last;
    logic line_gray;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [32:0] cordic_atan(input logic [3:0] i);
    logic signed [32:0] v;
    case (i)
      4'd0:    v = 33'sd536870912;
      4'd1:    v = 33'sd316933406;
      4'd2:    v = 33'sd167458907;
      4'd3:    v = 33'sd85004756;
      4'd4:    v = 33'sd42667331;
      4'd5:    v = 33'sd21354465;
      4'd6:    v = 33'sd10679838;
      4'd7:    v = 33'sd5340245;
      4'd8:    v = 33'sd2670163;
      4'd9:    v = 33'sd1335087;
      4'd10:   v = 33'sd667544;
      4'd11:   v = 33'sd333772;
      4'd12:   v = 33'sd166886;
      4'd13:   v = 33'sd83443;
      4'd14:   v = 33'sd41722;
      default: v = 33'sd20861;
    endcase
    return v;
  endfunction

endpackage

// File: design/scr_ifs.sv
// scr_ifs: valid/ready channel interfaces for requests, responses and config
// depends on scr_pkg
interface scr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [13:0]        size;
  logic signed [15:0] angle;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  modport source (output valid, req_type, pos_x, pos_y, size, angle, red, green, blue,
                  input ready);
  modport sink (input valid, req_type, pos_x, pos_y, size, angle, red, green, blue,
                output ready);
endinterface

interface scr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       status;
  modport source (output valid, red_out, green_out, blue_out, status, input ready);
  modport sink (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

interface scr_cfg_if;
  import scr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/scr_ram.sv
// scr_ram: generic one-write one-read ram with registered read data
// no dependencies
module scr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/scr_ctrl.sv
// scr_ctrl: sequencing state machine for access, circle and line requests
// depends on scr_pkg; drives datapath commands, reads datapath status
module scr_ctrl import scr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic [1:0] req_type_i,
  output logic       req_ready_o,
  input  dp_status_t st_i,
  output dp_cmd_t    cmd_o
);
  ctrl_state_e state_q, state_d;
  req_type_e   rt;

  assign rt = req_type_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          case (rt)
            REQ_CIRCLE: state_d = S_CINIT;
            REQ_LINE:   state_d = S_LINIT;
            default:    state_d = S_ACCESS;
          endcase
        end
      end
      S_ACCESS: state_d = S_RESP;
      S_RESP:   if (st_i.out_free) state_d = S_IDLE;
      S_CINIT:  state_d = S_CTEST;
      S_CTEST:  state_d = st_i.circ_go ? S_PT : S_RESP;
      S_PT:     state_d = S_NB;
      S_NB: begin
        if (st_i.nb_inside) state_d = S_NBW;
        else if (st_i.nb_last) state_d = S_RET;
      end
      S_NBW:    state_d = st_i.nb_last ? S_RET : S_NB;
      S_RET: begin
        if (st_i.is_circle) state_d = st_i.pt_last ? S_SQX : S_PT;
        else state_d = st_i.pt_last ? S_RESP : S_LNEXT;
      end
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_CSTEP;
      S_CSTEP:  state_d = S_CTEST;
      S_LINIT:  state_d = S_COR;
      S_COR:    if (st_i.cor_last) state_d = S_CDONE;
      S_CDONE:  state_d = S_LNEXT;
      S_LNEXT:  state_d = st_i.line_gray ? S_PT : S_MX;
      S_MX:     state_d = S_MY;
      S_MY:     state_d = S_PT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) cmd_o.op = OP_LOAD;
      end
      S_ACCESS: cmd_o.op = OP_ACCESS;
      S_RESP:   if (st_i.out_free) cmd_o.op = OP_PUBLISH;
      S_CINIT:  cmd_o.op = OP_CIR_INIT;
      S_CTEST:  cmd_o.op = OP_PT_RESET;
      S_PT:     cmd_o.op = OP_PT_LOAD;
      S_NB:     cmd_o.op = st_i.nb_inside ? OP_NB_READ : OP_NB_SKIP;
      S_NBW:    cmd_o.op = OP_NB_WRITE;
      S_RET:    cmd_o.op = OP_PT_NEXT;
      S_SQX:    cmd_o.op = OP_SQX;
      S_SQY:    cmd_o.op = OP_SQY;
      S_CSTEP:  cmd_o.op = OP_CIR_STEP;
      S_LINIT:  cmd_o.op = OP_COR_INIT;
      S_COR:    cmd_o.op = OP_COR_STEP;
      S_CDONE:  cmd_o.op = OP_COR_DONE;
      S_LNEXT:  cmd_o.op = OP_LINE_NEXT;
      S_MX:     cmd_o.op = OP_MULX;
      S_MY:     cmd_o.op = OP_MULY;
      default:  cmd_o.op = OP_NONE;
    endcase
  end
endmodule

// File: design/scr_datapath.sv
// scr_datapath: request registers, circle walk, cordic, line stepping,
// splat weights and saturating pixel update. depends on scr_pkg
module scr_datapath import scr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            st_o,
  input  logic [1:0]            req_type_i,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic [13:0]           size_i,
  input  logic signed [15:0]    angle_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic                  status_o,
  output logic                  ram_we_o,
  output logic [AW-1:0]         ram_waddr_o,
  output logic [47:0]           ram_wdata_o,
  output logic                  ram_re_o,
  output logic [AW-1:0]         ram_raddr_o,
  input  logic [47:0]           ram_rdata_i
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam logic [13:0] MAXW14 = 14'(MAX_WIDTH);
  localparam logic [13:0] MAXH14 = 14'(MAX_HEIGHT);
  localparam logic signed [48:0] HALF = 49'sd536870912;
  localparam logic signed [16:0] QUARTER = 17'sd16384;
  localparam logic signed [16:0] HALFTURN = 17'sd32768;

  dp_op_e op;
  assign op = cmd_i.op;

  logic [CFG_DATA_W-1:0] cfg_w_q, cfg_h_q;
  req_type_e          req_q;
  logic signed [15:0] ox_q, oy_q, ang_q;
  logic [13:0]        size_q;
  logic [15:0]        col_q [3];
  logic signed [15:0] wx_q, wy_q;
  logic [27:0]        r2_q;
  logic [29:0]        sq_q;
  logic [2:0]         k_q;
  logic [1:0]         nb_q;
  logic signed [17:0] fx_q, fy_q;
  logic [AW-1:0]      addr_q;
  logic [24:0]        prod_q [3];
  logic signed [32:0] cx_q, cy_q, cz_q, cs_q, sn_q;
  logic [3:0]         step_q;
  logic               neg_q;
  logic [10:0]        li_q, ll_q;
  logic               extra_q, gray_q, inside_q;
  logic signed [15:0] n_q;
  logic signed [17:0] offx_q, offy_q;
  logic               rsp_valid_q;
  logic [7:0]         rr_q, rg_q, rb_q;
  logic               rs_q;

  logic is_access;
  assign is_access = (req_q == REQ_WRITE) || (req_q == REQ_READ);

  // effective image size and neighbour geometry
  logic [13:0]        ew, eh;
  logic signed [13:0] pxs, pys;
  logic signed [15:0] xx_nb, yy_nb, ax, ay;
  logic               in_img;
  logic [AW-1:0]      addr;
  logic [4:0]         wxv, wyv;
  logic [9:0]         wt10;
  logic [8:0]         wt;

  assign ew = (14'(cfg_w_q) > MAXW14) ? MAXW14 : 14'(cfg_w_q);
  assign eh = (14'(cfg_h_q) > MAXH14) ? MAXH14 : 14'(cfg_h_q);
  assign pxs = fx_q[17:4];
  assign pys = fy_q[17:4];
  assign xx_nb = 16'(pxs) + 16'(nb_q[0]);
  assign yy_nb = 16'(pys) + 16'(nb_q[1]);
  assign ax = is_access ? ox_q : xx_nb;
  assign ay = is_access ? oy_q : yy_nb;
  assign in_img = !ax[15] && !ay[15] && (ax < $signed({2'b00, ew}))
                  && (ay < $signed({2'b00, eh}));
  assign addr = AW'(ay[YW-1:0]) * AW'(MAX_WIDTH) + AW'(ax[XW-1:0]);
  assign wxv = nb_q[0] ? {1'b0, fx_q[3:0]} : 5'd16 - {1'b0, fx_q[3:0]};
  assign wyv = nb_q[1] ? {1'b0, fy_q[3:0]} : 5'd16 - {1'b0, fy_q[3:0]};
  assign wt10 = 10'(wxv) * 10'(wyv);
  assign wt = wt10[8:0];

  // circle point offsets for the eight octants
  logic signed [16:0] px17, py17, ofx, ofy;
  assign px17 = 17'(wx_q);
  assign py17 = 17'(wy_q);
  always_comb begin
    case (k_q)
      3'd0:    begin ofx = px17;  ofy = py17;  end
      3'd1:    begin ofx = py17;  ofy = px17;  end
      3'd2:    begin ofx = -px17; ofy = -py17; end
      3'd3:    begin ofx = -py17; ofy = -px17; end
      3'd4:    begin ofx = px17;  ofy = -py17; end
      3'd5:    begin ofx = -px17; ofy = py17;  end
      3'd6:    begin ofx = py17;  ofy = -px17; end
      default: begin ofx = -py17; ofy = px17;  end
    endcase
  end

  // shared squarer for r*r, x*x and y*y
  logic [14:0] sq_in;
  logic [29:0] sqr;
  always_comb begin
    case (op)
      OP_CIR_INIT: sq_in = {1'b0, size_q};
      OP_SQX:      sq_in = wx_q[14:0];
      default:     sq_in = wy_q[14:0];
    endcase
  end
  assign sqr = 30'(sq_in) * 30'(sq_in);

  // cordic rotation
  logic signed [32:0] xs, ys, at;
  assign xs = cx_q >>> step_q;
  assign ys = cy_q >>> step_q;
  assign at = cordic_atan(step_q);

  logic signed [16:0] a17, afold;
  logic               afneg;
  assign a17 = 17'(ang_q);
  always_comb begin
    afold = a17;
    afneg = 1'b0;
    if (a17 > QUARTER) begin
      afold = a17 - HALFTURN;
      afneg = 1'b1;
    end else if (a17 < -QUARTER) begin
      afold = a17 + HALFTURN;
      afneg = 1'b1;
    end
  end

  // line offset multiplier, rounded to 1/16 pixel
  logic signed [32:0] mul_in;
  logic signed [48:0] mp, rnd;
  assign mul_in = (op == OP_MULX) ? cs_q : sn_q;
  assign mp = mul_in * n_q;
  assign rnd = (mp + HALF) >>> 30;

  // saturating channel update
  logic [15:0] sat [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [16:0] addv;
      logic [17:0] s;
      addv = 17'((prod_q[c] + 25'd128) >> 8);
      s = 18'(ram_rdata_i[47-16*c -: 16]) + 18'(addv);
      sat[c] = (s > 18'h0FFFF) ? 16'hFFFF : s[15:0];
    end
  end

  assign ram_we_o = ((op == OP_ACCESS) && (req_q == REQ_WRITE) && in_img)
                    || (op == OP_NB_WRITE);
  assign ram_waddr_o = (op == OP_NB_WRITE) ? addr_q : addr;
  assign ram_wdata_o = (op == OP_NB_WRITE) ? {sat[0], sat[1], sat[2]}
                                           : {col_q[0], col_q[1], col_q[2]};
  assign ram_re_o = ((op == OP_ACCESS) && (req_q == REQ_READ) && in_img)
                    || (op == OP_NB_READ);
  assign ram_raddr_o = addr;

  assign st_o.nb_inside = in_img;
  assign st_o.nb_last   = (nb_q == 2'd3);
  assign st_o.is_circle = (req_q == REQ_CIRCLE);
  assign st_o.pt_last   = (req_q == REQ_CIRCLE) ? (k_q == 3'd7) : gray_q;
  assign st_o.circ_go   = (wy_q < wx_q);
  assign st_o.cor_last  = (step_q == CORDIC_LAST);
  assign st_o.line_gray = !(li_q < ll_q) && !extra_q;
  assign st_o.out_free  = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= IMAGE_DIM_RESET;
      cfg_h_q     <= IMAGE_DIM_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i;
          REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (op == OP_PUBLISH) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        req_q    <= req_type_e'(req_type_i);
        ox_q     <= pos_x_i;
        oy_q     <= pos_y_i;
        size_q   <= size_i;
        ang_q    <= angle_i;
        col_q[0] <= {red_i, 8'h00};
        col_q[1] <= {green_i, 8'h00};
        col_q[2] <= {blue_i, 8'h00};
        inside_q <= 1'b0;
      end
      OP_ACCESS: inside_q <= in_img;
      OP_PUBLISH: begin
        rr_q <= (req_q == REQ_READ && inside_q) ? ram_rdata_i[47:40] : 8'h00;
        rg_q <= (req_q == REQ_READ && inside_q) ? ram_rdata_i[31:24] : 8'h00;
        rb_q <= (req_q == REQ_READ && inside_q) ? ram_rdata_i[15:8] : 8'h00;
        rs_q <= is_access && !inside_q;
      end
      OP_CIR_INIT: begin
        wx_q <= 16'(size_q);
        wy_q <= 16'sd0;
        r2_q <= sqr[27:0];
      end
      OP_PT_RESET: k_q <= 3'd0;
      OP_PT_LOAD: begin
        nb_q <= 2'd0;
        if (req_q == REQ_CIRCLE) begin
          fx_q <= 18'(ox_q) + 18'(ofx);
          fy_q <= 18'(oy_q) + 18'(ofy);
        end else if (gray_q) begin
          fx_q     <= 18'(ox_q);
          fy_q     <= 18'(oy_q);
          col_q[0] <= GRAY_LEVEL;
          col_q[1] <= GRAY_LEVEL;
          col_q[2] <= GRAY_LEVEL;
        end else begin
          fx_q <= 18'(ox_q) + offx_q;
          fy_q <= 18'(oy_q) + offy_q;
        end
      end
      OP_NB_READ: begin
        addr_q <= addr;
        for (int c = 0; c < 3; c++) prod_q[c] <= 25'(wt) * 25'(col_q[c]);
      end
      OP_NB_SKIP:  nb_q <= nb_q + 2'd1;
      OP_NB_WRITE: nb_q <= nb_q + 2'd1;
      OP_PT_NEXT:  k_q <= k_q + 3'd1;
      OP_SQX:      sq_q <= sqr;
      OP_SQY:      sq_q <= sq_q + sqr;
      OP_CIR_STEP: begin
        if (sq_q > 30'(r2_q)) wx_q <= wx_q - 16'sd16;
        else wy_q <= wy_q + 16'sd16;
      end
      OP_COR_INIT: begin
        cz_q   <= {afold, 16'h0000};
        cx_q   <= CORDIC_GAIN;
        cy_q   <= 33'sd0;
        step_q <= 4'd0;
        neg_q  <= afneg;
      end
      OP_COR_STEP: begin
        if (!cz_q[32]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
        step_q <= step_q + 4'd1;
      end
      OP_COR_DONE: begin
        cs_q    <= neg_q ? -cx_q : cx_q;
        sn_q    <= neg_q ? -cy_q : cy_q;
        li_q    <= 11'd1;
        ll_q    <= 11'((15'(size_q) + 15'd8) >> 4);
        extra_q <= (size_q[3:0] != 4'd0);
        gray_q  <= 1'b0;
      end
      OP_LINE_NEXT: begin
        if (li_q < ll_q) begin
          n_q  <= $signed({1'b0, li_q[10:0], 4'h0});
          li_q <= li_q + 11'd1;
        end else if (extra_q) begin
          n_q     <= $signed({2'b00, size_q}) - 16'sd16;
          extra_q <= 1'b0;
        end else begin
          gray_q <= 1'b1;
        end
      end
      OP_MULX: offx_q <= rnd[17:0];
      OP_MULY: offy_q <= rnd[17:0];
      default: ;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign red_out_o   = rr_q;
  assign green_out_o = rg_q;
  assign blue_out_o  = rb_q;
  assign status_o    = rs_q;
endmodule

// File: design/splat_circle_line_rasterizer_unit.sv
// Splat rasterizer over an RGB pixel store with 16-bit channels. One request
// at a time, one response per request; the response register lets the next
// request be taken while a response waits. A pixel write or read loads the
// request, accesses the store and publishes the response. Each circle walk
// step splats the eight octant points, then squares x and y and steps; a line
// runs its CORDIC setup, then computes and splats each point offset, and ends
// with the gray splat at its origin. A splat reads and writes back each
// neighbour inside the image and skips one outside; the memory has a single
// read port and a single write port. The store is not cleared at reset.
// depends on scr_pkg, scr_ifs, scr_ram, scr_ctrl, scr_datapath
module splat_circle_line_rasterizer_unit import scr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  scr_req_if.sink   req_i,
  scr_rsp_if.source rsp_o,
  scr_cfg_if.sink   cfg_i
);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [47:0]   ram_wdata, ram_rdata;

  assign cfg_i.ready = 1'b1;

  scr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  scr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .req_type_i  (req_i.req_type),
    .pos_x_i     (req_i.pos_x),
    .pos_y_i     (req_i.pos_y),
    .size_i      (req_i.size),
    .angle_i     (req_i.angle),
    .red_i       (req_i.red),
    .green_i     (req_i.green),
    .blue_i      (req_i.blue),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .red_out_o   (rsp_o.red_out),
    .green_out_o (rsp_o.green_out),
    .blue_out_o  (rsp_o.blue_out),
    .status_o    (rsp_o.status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  scr_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );
endmodule

// File: design/scr_checker.sv
// scr_checker: port-level assertions for the rasterizer top level
// bound to splat_circle_line_rasterizer_unit; no package use
module scr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] red_out_i,
  input logic [7:0] green_out_i,
  input logic [7:0] blue_out_i,
  input logic       status_i
);
  // a waiting response beat stays
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable({red_out_i, green_out_i, blue_out_i, status_i}))
    else $error("response payload changed while stalled");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // a rejected access returns zero bytes
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i |-> (red_out_i == 8'h00) && (green_out_i == 8'h00)
                                && (blue_out_i == 8'h00))
    else $error("failed access returned data");
endmodule

bind splat_circle_line_rasterizer_unit scr_checker u_scr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .red_out_i   (rsp_o.red_out),
  .green_out_i (rsp_o.green_out),
  .blue_out_i  (rsp_o.blue_out),
  .status_i    (rsp_o.status)
);

// File: tb/sv/splat_circle_line_rasterizer_unit_test.sv
`timescale 1ns / 1ps
// splat_circle_line_rasterizer_unit_test: self-checking bench for the splat rasterizer,
// with a pixel fill, a directed table, then random phases under several image sizes.
// depends on scr_pkg, scr_ifs and the rasterizer unit
module splat_circle_line_rasterizer_unit_test;
  import scr_pkg::*;

  localparam int STORE_W = MAX_WIDTH_DEF;
  localparam int STORE_D = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int FILL_DIM = 16;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 28;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    req_type_e          kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [13:0]        size;
    logic signed [15:0] angle;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } raster_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       status;
  } pixel_rsp_t;

  typedef struct {
    raster_req_t q;
    bit          typed;
    pixel_rsp_t  want;
  } directed_row_t;

  logic clk;
  logic rst_n;

  scr_req_if req_bus ();
  scr_rsp_if rsp_bus ();
  scr_cfg_if cfg_bus ();

  splat_circle_line_rasterizer_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  int unsigned pix_store [STORE_D][3];
  bit          pix_written [STORE_D];
  int unsigned img_w;
  int unsigned img_h;
  bit          calm;
  pixel_rsp_t  pending_rsp_q[$];
  int          mismatches;
  int          n_access;
  int          n_circle;
  int          n_line;
  int          n_rsp;

  longint atan_tab [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[splat_circle_line_rasterizer_unit] ERROR");
    $finish;
  end

  function automatic longint clip_dim(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // adds one bilinear splat, or with probe set only checks it touches written pixels
  function automatic bit splat(longint fx, longint fy, int unsigned col[3], bit probe);
    longint px, py, xx, yy, w, h, idx;
    int unsigned dx, dy, wy, wt, s;
    bit ok;
    ok = 1'b1;
    px = fx >>> 4;
    py = fy >>> 4;
    dx = int'(fx & 15);
    dy = int'(fy & 15);
    w = clip_dim(img_w, MAX_WIDTH_DEF);
    h = clip_dim(img_h, MAX_HEIGHT_DEF);
    for (int j = 0; j < 2; j++) begin
      yy = py + j;
      if (yy < 0 || yy >= h) continue;
      wy = j ? dy : 16 - dy;
      for (int i = 0; i < 2; i++) begin
        xx = px + i;
        if (xx < 0 || xx >= w) continue;
        wt = (i ? dx : 16 - dx) * wy;
        idx = yy * STORE_W + xx;
        if (!pix_written[idx]) ok = 1'b0;
        else if (!probe) begin
          for (int c = 0; c < 3; c++) begin
            s = pix_store[idx][c] + ((wt * col[c] + 128) >> 8);
            pix_store[idx][c] = (s > 65535) ? 65535 : s;
          end
        end
      end
    end
    return ok;
  endfunction

  function automatic bit circle_walk(longint cx, longint cy, longint r, int unsigned col[3],
                                     bit probe);
    longint x, y, r2;
    bit ok;
    ok = 1'b1;
    x = r;
    y = 0;
    r2 = r * r;
    while (y < x) begin
      ok &= splat(cx + x, cy + y, col, probe);
      ok &= splat(cx + y, cy + x, col, probe);
      ok &= splat(cx - x, cy - y, col, probe);
      ok &= splat(cx - y, cy - x, col, probe);
      ok &= splat(cx + x, cy - y, col, probe);
      ok &= splat(cx - x, cy + y, col, probe);
      ok &= splat(cx + y, cy - x, col, probe);
      ok &= splat(cx - y, cy + x, col, probe);
      if (x * x + y * y > r2) x -= 16;
      else y += 16;
    end
    return ok;
  endfunction

  function automatic void sin_cos(input int a, output longint cs, output longint sn);
    bit neg;
    longint z, x, y, xs, ys;
    neg = 1'b0;
    if (a > 16384) begin
      a -= 32768;
      neg = 1'b1;
    end else if (a < -16384) begin
      a += 32768;
      neg = 1'b1;
    end
    z = longint'(a) * 65536;
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_tab[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_tab[i];
      end
    end
    cs = neg ? -x : x;
    sn = neg ? -y : y;
  endfunction

  function automatic bit line_walk(longint ox, longint oy, longint len, int a,
                                   int unsigned col[3], bit probe);
    longint cs, sn, steps, n, half;
    int unsigned gray[3];
    bit ok;
    ok = 1'b1;
    half = 64'sd1 <<< 29;
    gray = '{GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL};
    sin_cos(a, cs, sn);
    steps = (len + 8) >>> 4;
    for (longint i = 1; i < steps; i++) begin
      n = i * 16;
      ok &= splat(ox + ((cs * n + half) >>> 30), oy + ((sn * n + half) >>> 30), col, probe);
    end
    if ((len & 15) != 0) begin
      n = len - 16;
      ok &= splat(ox + ((cs * n + half) >>> 30), oy + ((sn * n + half) >>> 30), col, probe);
    end
    ok &= splat(ox, oy, gray, probe);
    return ok;
  endfunction

  // returns 0 if the request would touch a pixel that was never written
  function automatic bit rasterize(raster_req_t q, bit probe, output pixel_rsp_t res);
    int unsigned col[3];
    longint idx;
    bit ok;
    ok = 1'b1;
    res = '{8'd0, 8'd0, 8'd0, 1'b0};
    col = '{int'(q.red) << 8, int'(q.green) << 8, int'(q.blue) << 8};
    if (q.kind == REQ_WRITE || q.kind == REQ_READ) begin
      if (q.x < 0 || q.x >= clip_dim(img_w, MAX_WIDTH_DEF) ||
          q.y < 0 || q.y >= clip_dim(img_h, MAX_HEIGHT_DEF)) begin
        res.status = 1'b1;
      end else begin
        idx = longint'(q.y) * STORE_W + longint'(q.x);
        if (q.kind == REQ_READ) begin
          ok = pix_written[idx];
          res.red   = ok ? pix_store[idx][0][15:8] : 8'd0;
          res.green = ok ? pix_store[idx][1][15:8] : 8'd0;
          res.blue  = ok ? pix_store[idx][2][15:8] : 8'd0;
        end else if (!probe) begin
          pix_written[idx] = 1'b1;
          for (int c = 0; c < 3; c++) pix_store[idx][c] = col[c];
        end
      end
    end else if (q.kind == REQ_CIRCLE) begin
      ok = circle_walk(q.x, q.y, q.size, col, probe);
    end else begin
      ok = line_walk(q.x, q.y, q.size, q.angle, col, probe);
    end
    return ok;
  endfunction

  function automatic raster_req_t mk_req(req_type_e kind, int x, int y, int size, int angle,
                                         int r, int g, int b);
    raster_req_t q;
    q.kind = kind;
    q.x = 16'(x);
    q.y = 16'(y);
    q.size = 14'(size);
    q.angle = 16'(angle);
    q.red = 8'(r);
    q.green = 8'(g);
    q.blue = 8'(b);
    return q;
  endfunction

  function automatic raster_req_t random_req();
    raster_req_t q;
    int sel;
    sel = $urandom_range(0, 99);
    q = mk_req(REQ_READ, 0, 0, $urandom_range(0, 240), $urandom, $urandom, $urandom, $urandom);
    if (sel < 25) q.kind = REQ_WRITE;
    else if (sel < 55) q.kind = REQ_READ;
    else if (sel < 80) q.kind = REQ_CIRCLE;
    else q.kind = REQ_LINE;
    if (q.kind == REQ_WRITE || q.kind == REQ_READ) begin
      if ($urandom_range(0, 7) == 0) begin
        q.x = 16'($urandom);
        q.y = 16'($urandom);
      end else begin
        q.x = 16'($urandom_range(0, FILL_DIM + 1));
        q.y = 16'($urandom_range(0, FILL_DIM + 1));
      end
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        q.x = 16'($urandom);
        q.y = 16'($urandom);
      end else begin
        q.x = 16'(int'($urandom_range(0, 24 * 16)) - 64);
        q.y = 16'(int'($urandom_range(0, 24 * 16)) - 64);
      end
      if ($urandom_range(0, 30) == 0) q.size = 14'($urandom);
    end
    return q;
  endfunction

  task automatic send_req(raster_req_t q, bit typed, pixel_rsp_t given);
    int gap;
    pixel_rsp_t want;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= q.kind;
    req_bus.pos_x    <= q.x;
    req_bus.pos_y    <= q.y;
    req_bus.size     <= q.size;
    req_bus.angle    <= q.angle;
    req_bus.red      <= q.red;
    req_bus.green    <= q.green;
    req_bus.blue     <= q.blue;
    do @(posedge clk); while (!req_bus.ready);
    void'(rasterize(q, 1'b0, want));
    pending_rsp_q.push_back(typed ? given : want);
    if (q.kind == REQ_CIRCLE) n_circle++;
    else if (q.kind == REQ_LINE) n_line++;
    else n_access++;
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w = value & 10'h3FF;
    else if (idx == REG_IMAGE_HEIGHT) img_h = value & 10'h3FF;
  endtask

  // response side: random stalls, compare each beat with the oldest prediction
  initial begin
    int stall;
    pixel_rsp_t want;
    stall = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
        n_rsp++;
        if (pending_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response beat at %0t", $realtime);
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_bus.red_out !== want.red || rsp_bus.green_out !== want.green ||
              rsp_bus.blue_out !== want.blue || rsp_bus.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected r%0d g%0d b%0d s%0d, got r%0d g%0d b%0d s%0d",
                       want.red, want.green, want.blue, want.status, rsp_bus.red_out,
                       rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.status);
          end
        end
        stall = calm ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    directed_row_t directed_rows[$];
    raster_req_t q;
    pixel_rsp_t none, dummy;
    int unsigned phase_w [N_PHASES] = '{16, 1, 0, 16, 1023, 7, 512, 16};
    int unsigned phase_h [N_PHASES] = '{16, 16, 16, 0, 1023, 13, 1, 9};
    bit ok;

    none = '{8'd0, 8'd0, 8'd0, 1'b0};
    mismatches = 0;
    n_access = 0;
    n_circle = 0;
    n_line = 0;
    n_rsp = 0;
    img_w = IMAGE_DIM_RESET;
    img_h = IMAGE_DIM_RESET;
    calm = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_WRITE;
    req_bus.pos_x = '0;
    req_bus.pos_y = '0;
    req_bus.size = '0;
    req_bus.angle = '0;
    req_bus.red = '0;
    req_bus.green = '0;
    req_bus.blue = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_IMAGE_WIDTH;
    cfg_bus.data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill the corner that drawing will land on
    for (int y = 0; y < FILL_DIM; y++)
      for (int x = 0; x < FILL_DIM; x++)
        send_req(mk_req(REQ_WRITE, x, y, 0, 0, $urandom, $urandom, $urandom), 1'b1, none);

    directed_rows.push_back('{mk_req(REQ_WRITE, 0, 0, 0, 0, 255, 0, 128), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              '{8'd255, 8'd0, 8'd128, 1'b0}});
    directed_rows.push_back('{mk_req(REQ_WRITE, 511, 511, 0, 0, 255, 255, 255), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_READ, 511, 511, 0, 0, 0, 0, 0), 1'b1,
                              '{8'd255, 8'd255, 8'd255, 1'b0}});
    directed_rows.push_back('{mk_req(REQ_WRITE, 512, 0, 0, 0, 1, 2, 3), 1'b1,
                              '{8'd0, 8'd0, 8'd0, 1'b1}});
    directed_rows.push_back('{mk_req(REQ_READ, -1, 5, 0, 0, 0, 0, 0), 1'b1,
                              '{8'd0, 8'd0, 8'd0, 1'b1}});
    directed_rows.push_back('{mk_req(REQ_READ, 0, -32768, 0, 0, 0, 0, 0), 1'b1,
                              '{8'd0, 8'd0, 8'd0, 1'b1}});
    directed_rows.push_back('{mk_req(REQ_WRITE, 32767, 0, 0, 0, 9, 9, 9), 1'b1,
                              '{8'd0, 8'd0, 8'd0, 1'b1}});
    directed_rows.push_back('{mk_req(REQ_READ, 0, 512, 0, 0, 0, 0, 0), 1'b1,
                              '{8'd0, 8'd0, 8'd0, 1'b1}});
    directed_rows.push_back('{mk_req(REQ_WRITE, 3, 3, 0, 0, 0, 0, 0), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_CIRCLE, 128, 128, 0, 0, 255, 255, 255), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_CIRCLE, 128, 128, 48, 0, 255, 0, 64), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_CIRCLE, 0, 0, 32, 0, 255, 255, 255), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_CIRCLE, -32768, -32768, 16383, 0, 1, 1, 1),
                              1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, 64, 64, 0, 0, 200, 100, 50), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, 128, 128, 40, 0, 255, 255, 255), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, 128, 128, 40, 16384, 10, 20, 30), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, 128, 128, 40, -16384, 0, 0, 0), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, 128, 128, 24, 32767, 255, 0, 0), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, 128, 128, 8, -32768, 0, 255, 0), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, 128, 128, 33, 16385, 0, 0, 255), 1'b1, none});
    directed_rows.push_back('{mk_req(REQ_LINE, -32768, -32768, 16383, -16384, 255, 255, 255),
                              1'b1, none});
    directed_rows.push_back('{mk_req(REQ_READ, 8, 8, 0, 0, 0, 0, 0), 1'b0, none});
    directed_rows.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed_rows.push_back('{mk_req(REQ_READ, 1, 1, 0, 0, 0, 0, 0), 1'b0, none});
    foreach (directed_rows[i]) send_req(directed_rows[i].q, directed_rows[i].typed,
                                        directed_rows[i].want);

    // pause until every response is back before touching the image size
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p == 0) begin
        write_reg(REG_SPARE_A, 5);
        write_reg(REG_SPARE_B, 1023);
      end
      write_reg(REG_IMAGE_WIDTH, phase_w[p]);
      write_reg(REG_IMAGE_HEIGHT, phase_h[p]);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        q = random_req();
        ok = rasterize(q, 1'b1, dummy);
        for (int t = 0; t < 20 && !ok; t++) begin
          q = random_req();
          ok = rasterize(q, 1'b1, dummy);
        end
        if (!ok) q = mk_req(REQ_READ, -1, -1, 0, 0, 0, 0, 0);
        send_req(q, 1'b0, none);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pixel accesses, %0d circles, %0d lines; %0d responses checked",
             n_access, n_circle, n_line, n_rsp);
    $display("image sizes from 0 to 1023 per side, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("[splat_circle_line_rasterizer_unit] OK");
    end else begin
      $display("[splat_circle_line_rasterizer_unit] ERROR");
    end
    $finish;
  end

endmodule
